/* rtl/sdmx_pkg.sv */
// Shared types and constants for the stream metadata demultiplexer.
`default_nettype none

package sdmx_pkg;

  // Metadata text store
  localparam int unsigned MetaStoreBytes = 4096;
  localparam int unsigned StoreAddrW     = $clog2(MetaStoreBytes);
  localparam int unsigned FillW          = StoreAddrW + 1;

  // Field widths
  localparam int unsigned IntervalW = 20;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned MetaW     = 12;
  // One length unit is sixteen text bytes
  localparam int unsigned LenShift  = 4;

  typedef enum logic [1:0] {
    KIND_AUDIO  = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_META   = 2'd2
  } byte_kind_e;

  typedef enum logic {
    PHASE_AUDIO = 1'b0,
    PHASE_META  = 1'b1
  } parse_phase_e;

  // Input beat
  typedef struct packed {
    logic [ByteW-1:0] stream_byte;
    logic             connection_start;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    byte_kind_e       byte_kind;
    logic [ByteW-1:0] data_value;
    logic [MetaW-1:0] meta_index;
    logic [MetaW-1:0] meta_length;
    logic             block_end;
    logic             meta_changed;
  } out_beat_t;

  // Labelled byte handed from the parser to the compare stage
  typedef struct packed {
    byte_kind_e       kind;
    logic [ByteW-1:0] data;
    logic [MetaW-1:0] index;
    logic [MetaW-1:0] length;
    logic             block_end;
  } sdmx_item_t;

  // Store access issued by the parser
  typedef struct packed {
    logic                  en;
    logic                  clear;
    logic [StoreAddrW-1:0] addr;
    logic [ByteW-1:0]      wdata;
  } store_req_t;

endpackage

`default_nettype wire

/* rtl/sdmx_parser.sv */
// Stream parser: position counters and audio/length/text labelling of each beat.
`default_nettype none

module sdmx_parser (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [sdmx_pkg::IntervalW-1:0]   interval_i,
  input  wire logic                             accept_i,
  input  wire sdmx_pkg::in_beat_t               beat_i,
  output sdmx_pkg::sdmx_item_t                  item_o,
  output sdmx_pkg::store_req_t                  req_o
);
  import sdmx_pkg::*;

  parse_phase_e           phase_q, phase_d;
  logic [IntervalW-1:0]   pos_q, pos_d;
  logic [MetaW-1:0]       rem_q, rem_d;
  logic [MetaW-1:0]       cur_q, cur_d;

  // State after an optional connection restart
  parse_phase_e           phase_eff;
  logic [IntervalW-1:0]   pos_eff;
  logic [MetaW-1:0]       rem_eff;
  logic [MetaW-1:0]       cur_eff;
  logic [MetaW-1:0]       len_byte;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_AUDIO;
      pos_q   <= '0;
      rem_q   <= '0;
      cur_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      cur_q   <= cur_d;
    end
  end

  // Next state and labelling
  always_comb begin
    phase_eff = beat_i.connection_start ? PHASE_AUDIO : phase_q;
    pos_eff   = beat_i.connection_start ? '0 : pos_q;
    rem_eff   = beat_i.connection_start ? '0 : rem_q;
    cur_eff   = beat_i.connection_start ? '0 : cur_q;
    len_byte  = {beat_i.stream_byte, {LenShift{1'b0}}};

    phase_d = phase_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    cur_d   = cur_q;

    item_o.kind      = KIND_AUDIO;
    item_o.data      = beat_i.stream_byte;
    item_o.index     = '0;
    item_o.length    = '0;
    item_o.block_end = 1'b0;

    req_o.en    = 1'b0;
    req_o.clear = accept_i & beat_i.connection_start;
    req_o.addr  = StoreAddrW'(cur_eff);
    req_o.wdata = beat_i.stream_byte;

    if (accept_i) begin
      phase_d = phase_eff;
      pos_d   = pos_eff;
      rem_d   = rem_eff;
      cur_d   = cur_eff;

      if (interval_i == '0) begin
        // Extraction off: everything is audio, an open block is dropped
        phase_d = PHASE_AUDIO;
        rem_d   = '0;
        cur_d   = '0;
      end else begin
        case (phase_eff)
          PHASE_META: begin
            item_o.kind   = KIND_META;
            item_o.index  = cur_eff;
            item_o.length = cur_eff + rem_eff;
            req_o.en      = 1'b1;
            cur_d         = cur_eff + MetaW'(1);
            if (rem_eff <= MetaW'(1)) begin
              item_o.block_end = 1'b1;
              phase_d          = PHASE_AUDIO;
              rem_d            = '0;
              cur_d            = '0;
              pos_d            = '0;
            end else begin
              rem_d = rem_eff - MetaW'(1);
            end
          end
          PHASE_AUDIO: begin
            if (pos_eff >= interval_i) begin
              item_o.kind   = KIND_LENGTH;
              item_o.length = len_byte;
              pos_d         = '0;
              if (beat_i.stream_byte == '0) begin
                // Empty block closes at once
                item_o.block_end = 1'b1;
              end else begin
                phase_d = PHASE_META;
                rem_d   = len_byte;
                cur_d   = '0;
              end
            end else begin
              pos_d = pos_eff + IntervalW'(1);
            end
          end
          default: begin
            phase_d = PHASE_AUDIO;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sdmx_store.sv */
// Metadata text store: single-port RAM with read-old-data and a fill mark.
`default_nettype none

module sdmx_store (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sdmx_pkg::store_req_t        req_i,
  output logic [sdmx_pkg::ByteW-1:0]       rd_data_o
);
  import sdmx_pkg::*;

  logic [ByteW-1:0] mem [MetaStoreBytes];
  logic [ByteW-1:0] rd_q;
  logic             hit_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] addr_ext;
  logic             hit;

  // Entries below the fill mark were written since the last clear;
  // text is written in increasing index order from zero.
  assign addr_ext = FillW'(req_i.addr);
  assign hit      = addr_ext < fill_q;

  always_comb begin
    fill_d = fill_q;
    if (req_i.clear) begin
      fill_d = '0;
    end else if (req_i.en && !hit) begin
      fill_d = addr_ext + FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // RAM: old contents come out while the new byte goes in
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      mem[req_i.addr] <= req_i.wdata;
      rd_q            <= mem[req_i.addr];
      hit_q           <= hit;
    end
  end

  // Unwritten entries read as zero
  assign rd_data_o = hit_q ? rd_q : '0;

endmodule

`default_nettype wire

/* rtl/sdmx_compare.sv */
// Compare stage and output register: change detection over a metadata block.
`default_nettype none

module sdmx_compare (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire sdmx_pkg::sdmx_item_t        item_i,
  input  wire logic [sdmx_pkg::ByteW-1:0]  rd_data_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output sdmx_pkg::out_beat_t              out_beat_o
);
  import sdmx_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  sdmx_item_t s1_item_q;
  logic       out_valid_q, out_valid_d;
  out_beat_t  out_q, out_d;
  logic       acc_q, acc_d;
  logic       advance;
  logic       differs;
  logic       is_meta;

  // Stage 1 moves on when the output register is free or being drained
  assign advance    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | ~out_valid_q | out_ready_i;

  assign is_meta = (s1_item_q.kind == KIND_META);
  assign differs = (rd_data_i != s1_item_q.data);

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    acc_d       = acc_q;

    if (accept_i) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end

    if (advance) begin
      out_valid_d        = 1'b1;
      out_d.byte_kind    = s1_item_q.kind;
      out_d.data_value   = s1_item_q.data;
      out_d.meta_index   = s1_item_q.index;
      out_d.meta_length  = s1_item_q.length;
      out_d.block_end    = s1_item_q.block_end;
      out_d.meta_changed = is_meta & s1_item_q.block_end & (acc_q | differs);
      // Difference flag lives only across the text beats of one block
      acc_d = (is_meta & ~s1_item_q.block_end) ? (acc_q | differs) : 1'b0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_item_q <= item_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

/* rtl/stream_metadata_demultiplexer.sv */
// Top level of the stream metadata demultiplexer.
`default_nettype none

// Labels each received stream byte as audio, metadata length byte or metadata
// text byte, and flags on the last text byte of a block whether the text
// differs from the previous block. One result beat leaves for every input
// beat. Sustained rate is one byte per cycle unless the output stalls; a byte
// passes stage 1 and the 4096-byte text store's registered read, then the
// output register. Each text byte reads the old entry and writes the new one
// in the same RAM cycle. A connection start clears the store in no time: a
// fill mark makes entries not yet written since the clear read as zero, so the
// block never pauses for a clearing pass. Write metadata_interval only while
// the block is idle; zero turns extraction off and passes every byte as audio.

module stream_metadata_demultiplexer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [sdmx_pkg::IntervalW-1:0]   cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire sdmx_pkg::in_beat_t               in_beat_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output sdmx_pkg::out_beat_t                   out_beat_o
);
  import sdmx_pkg::*;

  logic [IntervalW-1:0] interval_q;
  logic                 accept;
  sdmx_item_t           item;
  store_req_t           req;
  logic [ByteW-1:0]     rd_data;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  assign accept = in_valid_i & in_ready_o;

  sdmx_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .interval_i (interval_q),
    .accept_i   (accept),
    .beat_i     (in_beat_i),
    .item_o     (item),
    .req_o      (req)
  );

  sdmx_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  sdmx_compare u_compare (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .rd_data_i   (rd_data),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire
